[sv/fbcm_pkg.sv]
// shared constants, codes and controller/datapath interface types for the chain manager
package fbcm_pkg;

   localparam int NUM_SLOTS       = 16;
   localparam int BLOCK_COUNT     = 128;
   localparam int BYTES_PER_BLOCK = 64;

   localparam int SLOT_W  = 4;
   localparam int BLK_W   = $clog2(BLOCK_COUNT);
   localparam int LINK_W  = 8;
   localparam int SCAN_W  = BLK_W + 1;
   localparam int CNT_W   = 8;
   localparam int OFF_W   = $clog2(BYTES_PER_BLOCK);
   localparam int BYTES_D = BLOCK_COUNT * BYTES_PER_BLOCK;
   localparam int BYTE_AW = $clog2(BYTES_D);
   localparam int SIZE_W  = 14;
   localparam int POS_W   = 13;

   localparam logic [LINK_W-1:0] MARK_END = LINK_W'(254);

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_SIZE   = 2'd1,
      KIND_WRITE  = 2'd2,
      KIND_NOP    = 2'd3
   } fbcm_kind_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_SLOT  = 3'd1,
      ST_NO_BLOCK = 3'd2,
      ST_UNUSED   = 3'd3,
      ST_BEYOND   = 3'd4
   } fbcm_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_C_SCAN,
      S_C_CLAIM,
      S_G_RD,
      S_G_CHK,
      S_G_TEST,
      S_G_SCAN,
      S_G_LINK_A,
      S_G_LINK_B,
      S_CUT_RD,
      S_CUT_CHK,
      S_CUT_WALK,
      S_CUT_NEXT,
      S_W_RD,
      S_W_CHK
   } fbcm_state_type;

   typedef struct packed {
      logic            load_req;
      logic            scan_step;
      logic            cur_from_link;
      logic            cur_from_scan;
      logic            cnt_dec;
      logic            link_rd;
      logic            rd_nxt;
      logic            link_wr;
      logic            wr_addr_scan;
      logic            wr_data_scan;
      logic            nxt_from_link;
      logic            free_clr;
      logic            free_set;
      logic            slot_claim;
      logic            byte_wr;
      logic            set_status;
      fbcm_status_type status;
      logic            load_rsp;
   } fbcm_cmd_type;

   typedef struct packed {
      fbcm_kind_type kind;
      logic          head_ok;
      logic          slot_found;
      logic          cnt_zero;
      logic          link_end;
      logic          scan_hit;
      logic          scan_over;
      logic          nxt_end;
      logic          rsp_free;
   } fbcm_stat_type;

endpackage

[sv/fbcm_ctrl.sv]
// controller state machine sequencing scans, chain walks and cuts
module fbcm_ctrl
   import fbcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  fbcm_stat_type stat,
   output fbcm_cmd_type  cmd
);

   fbcm_state_type state_ff, state_in;
   logic           done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // finishing arms also return to idle through the result register
   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_CREATE: begin
                  if (!stat.slot_found) done = 1'b1;
                  else state_in = S_C_SCAN;
               end
               KIND_SIZE: begin
                  if (!stat.head_ok) done = 1'b1;
                  else if (stat.cnt_zero) state_in = S_CUT_RD;
                  else state_in = S_G_RD;
               end
               KIND_WRITE: begin
                  if (!stat.head_ok || stat.cnt_zero) done = 1'b1;
                  else state_in = S_W_RD;
               end
               KIND_NOP: done = 1'b1;
            endcase
         end
         S_C_SCAN: begin
            if (stat.scan_hit) state_in = S_C_CLAIM;
            else if (stat.scan_over) done = 1'b1;
         end
         S_C_CLAIM: done = 1'b1;
         S_G_RD:    state_in = S_G_CHK;
         S_G_CHK: begin
            if (stat.link_end) state_in = S_G_SCAN;
            else state_in = S_G_TEST;
         end
         S_G_TEST: begin
            if (stat.cnt_zero) state_in = S_CUT_RD;
            else state_in = S_G_RD;
         end
         S_G_SCAN: begin
            if (stat.scan_hit) state_in = S_G_LINK_A;
            else if (stat.scan_over) done = 1'b1;
         end
         S_G_LINK_A: state_in = S_G_LINK_B;
         S_G_LINK_B: state_in = S_G_TEST;
         S_CUT_RD:   state_in = S_CUT_CHK;
         S_CUT_CHK:  state_in = S_CUT_WALK;
         S_CUT_WALK: begin
            if (stat.nxt_end) done = 1'b1;
            else state_in = S_CUT_NEXT;
         end
         S_CUT_NEXT: state_in = S_CUT_WALK;
         S_W_RD:     state_in = S_W_CHK;
         S_W_CHK: begin
            if (stat.link_end) done = 1'b1;
            else state_in = S_DECODE;
         end
         default: state_in = S_IDLE;
      endcase
      // hold a finished item until the result register is free
      if (done) state_in = stat.rsp_free ? S_IDLE : state_ff;
   end

   always_comb begin
      cmd        = '0;
      cmd.status = ST_OK;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_CREATE: begin
                  cmd.set_status = !stat.slot_found;
                  cmd.status     = ST_NO_SLOT;
               end
               KIND_SIZE, KIND_WRITE: begin
                  cmd.set_status = !stat.head_ok;
                  cmd.status     = ST_UNUSED;
                  // write that reached its block stores here
                  cmd.byte_wr    = stat.head_ok && stat.cnt_zero &&
                                   stat.kind == KIND_WRITE && stat.rsp_free;
               end
               KIND_NOP: ;
            endcase
         end
         S_C_SCAN: begin
            cmd.scan_step  = !stat.scan_hit && !stat.scan_over;
            cmd.set_status = stat.scan_over;
            cmd.status     = ST_NO_BLOCK;
         end
         S_C_CLAIM: begin
            // claim only together with the result load
            cmd.slot_claim   = stat.rsp_free;
            cmd.free_clr     = stat.rsp_free;
            cmd.link_wr      = stat.rsp_free;
            cmd.wr_addr_scan = 1'b1;
         end
         S_G_RD: cmd.link_rd = 1'b1;
         S_G_CHK: begin
            cmd.cur_from_link = !stat.link_end;
            cmd.cnt_dec       = !stat.link_end;
         end
         S_G_TEST: ;
         S_G_SCAN: begin
            cmd.scan_step  = !stat.scan_hit && !stat.scan_over;
            cmd.set_status = stat.scan_over;
            cmd.status     = ST_NO_BLOCK;
         end
         S_G_LINK_A: begin
            cmd.link_wr      = 1'b1;
            cmd.wr_data_scan = 1'b1;
         end
         S_G_LINK_B: begin
            cmd.link_wr       = 1'b1;
            cmd.wr_addr_scan  = 1'b1;
            cmd.free_clr      = 1'b1;
            cmd.cur_from_scan = 1'b1;
            cmd.cnt_dec       = 1'b1;
            cmd.scan_step     = 1'b1;
         end
         S_CUT_RD: cmd.link_rd = 1'b1;
         S_CUT_CHK: begin
            cmd.nxt_from_link = 1'b1;
            cmd.link_wr       = 1'b1;
         end
         S_CUT_WALK: begin
            cmd.link_rd  = !stat.nxt_end;
            cmd.rd_nxt   = 1'b1;
            cmd.free_set = !stat.nxt_end;
         end
         S_CUT_NEXT: cmd.nxt_from_link = 1'b1;
         S_W_RD: cmd.link_rd = 1'b1;
         S_W_CHK: begin
            cmd.set_status    = stat.link_end;
            cmd.status        = ST_BEYOND;
            cmd.cur_from_link = !stat.link_end;
            cmd.cnt_dec       = !stat.link_end;
         end
         default: ;
      endcase
      cmd.load_rsp = done && stat.rsp_free;
   end

endmodule

[sv/fbcm_dpath.sv]
// datapath: slot table, free map, link and byte memories, walk registers, result register
module fbcm_dpath
   import fbcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  fbcm_cmd_type      cmd,
   output fbcm_stat_type     stat,
   input  logic [1:0]        req_kind,
   input  logic [SLOT_W-1:0] req_index,
   input  logic [SIZE_W-1:0] req_size,
   input  logic [POS_W-1:0]  req_pos,
   input  logic [7:0]        req_byte,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [2:0]        rsp_status
);

   logic [NUM_SLOTS-1:0]   used_ff;
   logic [BLK_W-1:0]       first_ff [NUM_SLOTS];
   logic [BLOCK_COUNT-1:0] free_ff;
   logic [LINK_W-1:0]      link_mem [BLOCK_COUNT];
   logic [7:0]             byte_mem [BYTES_D];
   logic [LINK_W-1:0]      link_q_ff;

   fbcm_kind_type         kind_ff;
   logic [SLOT_W-1:0]     idx_ff, slot_ff;
   logic [BLK_W-1:0]      cur_ff;
   logic [LINK_W-1:0]     nxt_ff;
   logic [SCAN_W-1:0]     scan_ff;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [OFF_W-1:0]      off_ff;
   logic [7:0]            data_ff;
   fbcm_status_type       status_ff;
   logic                  rsp_valid_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [2:0]            rsp_status_ff;

   logic [SLOT_W-1:0]     found;
   logic                  found_ok;
   logic [BLK_W-1:0]      scan_idx, rd_addr, wr_addr;
   logic [LINK_W-1:0]     wr_data;
   logic [SIZE_W:0]       size_up;
   logic [BYTE_AW-1:0]    byte_addr;

   // lowest free slot
   always_comb begin
      found    = '0;
      found_ok = 1'b0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (!used_ff[s]) begin
            found    = SLOT_W'(s);
            found_ok = 1'b1;
         end
      end
   end

   assign scan_idx  = scan_ff[BLK_W-1:0];
   assign rd_addr   = cmd.rd_nxt ? nxt_ff[BLK_W-1:0] : cur_ff;
   assign wr_addr   = cmd.wr_addr_scan ? scan_idx : cur_ff;
   assign wr_data   = cmd.wr_data_scan ? LINK_W'(scan_ff) : MARK_END;
   assign size_up   = (SIZE_W+1)'(req_size) + (SIZE_W+1)'(BYTES_PER_BLOCK - 1);
   assign byte_addr = BYTE_AW'(cur_ff) * BYTE_AW'(BYTES_PER_BLOCK) + BYTE_AW'(off_ff);

   // number of extra blocks for set size, block hops for write
   always_comb begin
      if (req_kind == KIND_SIZE) begin
         cnt_in = (size_up / BYTES_PER_BLOCK == '0) ? '0
                  : CNT_W'(size_up / BYTES_PER_BLOCK - 1'b1);
      end else begin
         cnt_in = CNT_W'(req_pos / BYTES_PER_BLOCK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         free_ff <= '1;
      end else begin
         if (cmd.slot_claim) used_ff[found] <= 1'b1;
         if (cmd.free_clr) free_ff[scan_idx] <= 1'b0;
         if (cmd.free_set) free_ff[nxt_ff[BLK_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.slot_claim) first_ff[found] <= scan_idx;
      if (cmd.link_wr) link_mem[wr_addr] <= wr_data;
      if (cmd.link_rd) link_q_ff <= link_mem[rd_addr];
      if (cmd.byte_wr) byte_mem[byte_addr] <= data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.load_req) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff   <= fbcm_kind_type'(req_kind);
         idx_ff    <= req_index;
         slot_ff   <= req_index;
         cur_ff    <= first_ff[req_index];
         cnt_ff    <= cnt_in;
         off_ff    <= OFF_W'(req_pos % BYTES_PER_BLOCK);
         data_ff   <= req_byte;
         status_ff <= ST_OK;
      end else begin
         if (cmd.cur_from_link) cur_ff <= link_q_ff[BLK_W-1:0];
         if (cmd.cur_from_scan) cur_ff <= scan_idx;
         if (cmd.cnt_dec) cnt_ff <= cnt_ff - 1'b1;
         if (cmd.nxt_from_link) nxt_ff <= link_q_ff;
         if (cmd.slot_claim) slot_ff <= found;
         if (cmd.set_status) status_ff <= cmd.status;
      end
   end

   // result register frees the request side while a result waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_slot_ff   <= cmd.slot_claim ? found : slot_ff;
         rsp_status_ff <= cmd.set_status ? cmd.status : status_ff;
      end
   end

   assign stat.kind       = kind_ff;
   assign stat.head_ok    = used_ff[idx_ff];
   assign stat.slot_found = found_ok;
   assign stat.cnt_zero   = cnt_ff == '0;
   assign stat.link_end   = link_q_ff >= LINK_W'(BLOCK_COUNT);
   assign stat.scan_over  = scan_ff == SCAN_W'(BLOCK_COUNT);
   assign stat.scan_hit   = !stat.scan_over && free_ff[scan_idx];
   assign stat.nxt_end    = nxt_ff >= LINK_W'(BLOCK_COUNT);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= SCAN_W'(BLOCK_COUNT))
      else $error("scan pointer past block count");

   a_claim_free: assert property (@(posedge clock) disable iff (reset)
      cmd.free_clr |-> stat.scan_hit)
      else $error("claiming a block that is not free");

   a_store_hops: assert property (@(posedge clock) disable iff (reset)
      cmd.byte_wr |-> stat.cnt_zero && stat.head_ok)
      else $error("byte stored before chain walk finished");

   a_rsp_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("result overwritten before taken");

endmodule

[sv/fat_block_chain_manager.sv]
// top level of the fat-style chain manager: controller plus datapath
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tuser kind, tdata index/size/position/byte
//   rsp_     out  rsp_tvalid/tready     tdata slot/status
//
// one item at a time; an item is accepted in idle and its result goes to the result register:
// create finishes at decode without a free slot, else scans for a free block and claims it;
// write walks one block hop per link memory read, then stores the byte; set size walks
// the blocks kept, links each added block found by a free-block scan that covers each block
// at most once per item, and then frees the blocks past the new end. reset empties the slot
// table and frees every block. a finished result waits in the output register; the next item is
// accepted meanwhile, and only finishing stalls while rsp_tready is low and a result is held.
module fat_block_chain_manager
   import fbcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // file_index, new_size, position, data_byte, zero pad
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // slot, status, zero pad
);

   fbcm_cmd_type      cmd;
   fbcm_stat_type     stat;
   logic [SLOT_W-1:0] rsp_slot;
   logic [2:0]        rsp_status;

   fbcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fbcm_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_index  (req_tdata[3:0]),
      .req_size   (req_tdata[17:4]),
      .req_pos    (req_tdata[30:18]),
      .req_byte   (req_tdata[38:31]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {1'b0, rsp_status, rsp_slot};

endmodule

[tb/fat_block_chain_manager_chk.sv]
// checker for the chain manager: watches both channels, predicts each result and compares
module fat_block_chain_manager_chk
   import fbcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [3:0] slot;
      logic [2:0] status;
   } fat_rsp_type;

   localparam logic [7:0] FREE_MARK = 8'd255;

   logic [7:0]  slot_head [NUM_SLOTS];
   logic [7:0]  next_blk  [BLOCK_COUNT];
   fat_rsp_type want_q [$];

   function automatic int first_free_block();
      for (int b = 0; b < BLOCK_COUNT; b++)
         if (next_blk[b] == FREE_MARK) return b;
      return -1;
   endfunction

   function automatic int follow(int b);
      if (next_blk[b] >= BLOCK_COUNT) return -1;
      return next_blk[b];
   endfunction

   function automatic fbcm_status_type resize_chain(int bn, int size);
      int blocks;
      int more;
      int n;
      int fresh;
      int nn;
      blocks = (size + BYTES_PER_BLOCK - 1) / BYTES_PER_BLOCK;
      more = blocks > 0 ? blocks - 1 : 0;
      while (more > 0) begin
         n = follow(bn);
         if (n < 0) begin
            fresh = first_free_block();
            if (fresh < 0) return ST_NO_BLOCK;
            next_blk[bn] = 8'(fresh);
            next_blk[fresh] = MARK_END;
            n = fresh;
         end
         bn = n;
         more--;
      end
      n = follow(bn);
      next_blk[bn] = MARK_END;
      for (int g = 0; n >= 0 && g < BLOCK_COUNT; g++) begin
         nn = follow(n);
         next_blk[n] = FREE_MARK;
         n = nn;
      end
      return ST_OK;
   endfunction

   function automatic fat_rsp_type predict_op(logic [1:0] kind, logic [39:0] d);
      fat_rsp_type r;
      int idx;
      int s;
      int b;
      int hops;
      idx = d[3:0];
      r.slot = d[3:0];
      r.status = ST_OK;
      case (fbcm_kind_type'(kind))
         KIND_CREATE: begin
            s = -1;
            for (int i = NUM_SLOTS - 1; i >= 0; i--)
               if (slot_head[i] == FREE_MARK) s = i;
            b = first_free_block();
            if (s < 0) r.status = ST_NO_SLOT;
            else if (b < 0) r.status = ST_NO_BLOCK;
            else begin
               slot_head[s] = 8'(b);
               next_blk[b] = MARK_END;
               r.slot = 4'(s);
            end
         end
         KIND_SIZE, KIND_WRITE: begin
            b = (idx < NUM_SLOTS && slot_head[idx] < BLOCK_COUNT) ? slot_head[idx] : -1;
            if (b < 0) r.status = ST_UNUSED;
            else if (kind == KIND_SIZE) r.status = resize_chain(b, d[17:4]);
            else begin
               hops = d[30:18] / BYTES_PER_BLOCK;
               while (hops > 0 && b >= 0) begin
                  b = follow(b);
                  hops--;
               end
               if (b < 0) r.status = ST_BEYOND;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   assign pending = want_q.size();

   always @(posedge clock) begin
      fat_rsp_type got;
      fat_rsp_type exp_r;
      if (reset) begin
         foreach (slot_head[i]) slot_head[i] <= FREE_MARK;
         foreach (next_blk[i]) next_blk[i] <= FREE_MARK;
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) want_q.push_back(predict_op(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.slot = rsp_tdata[3:0];
            got.status = rsp_tdata[6:4];
            if (want_q.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("unexpected item: %h", rsp_tdata);
            end else begin
               exp_r = want_q.pop_front();
               if (exp_r != got || rsp_tdata[7] !== 1'b0) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("slot/status expected %0d/%0d got %0d/%0d", exp_r.slot,
                              exp_r.status, got.slot, got.status);
               end
            end
         end
      end
   end

endmodule

[tb/fat_block_chain_manager_tb.sv]
// testbench top: drives operations into the chain manager and gives the verdict
module fat_block_chain_manager_tb;
   import fbcm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   bit          calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fat_block_chain_manager i_dut (.*);

   fat_block_chain_manager_chk i_chk (.*);

   // receiver stalls at random outside the calm stretch
   always @(posedge clock)
      rsp_tready <= calm || ($urandom_range(99) >= 21);

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("fat_block_chain_manager: mismatch");
         $finish;
      end
   end

   // valid stays high after acceptance until an idle cycle or a drain drops it
   task automatic send_op(fbcm_kind_type kind, int idx, int size, int pos, int dbyte);
      if (!calm)
         while ($urandom_range(99) < 21) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, 8'(dbyte), 13'(pos), 14'(size), 4'(idx)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int k;
      int r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // unused files, then fill every slot, then slot exhaustion, then resizes and writes on slots 0 and 1
      send_op(KIND_SIZE, 15, 8192, 0, 0);
      send_op(KIND_WRITE, 0, 0, 8191, 8'hff);
      send_op(KIND_NOP, 9, 0, 0, 0);
      for (int i = 0; i < NUM_SLOTS; i++) send_op(KIND_CREATE, 15 - i, 0, 0, 0);
      send_op(KIND_CREATE, 5, 0, 0, 0);
      send_op(KIND_WRITE, 0, 0, 64, 8'h00);
      send_op(KIND_SIZE, 0, 8192, 0, 0);
      send_op(KIND_WRITE, 0, 0, 8191, 8'ha5);
      send_op(KIND_SIZE, 1, 8192, 0, 0);
      send_op(KIND_SIZE, 0, 0, 0, 0);
      send_op(KIND_SIZE, 1, 130, 0, 0);
      send_op(KIND_WRITE, 1, 0, 191, 8'h5a);
      send_op(KIND_WRITE, 1, 0, 192, 8'h5a);
      drain();
      for (int n = 0; n < 750; n++) begin
         calm = (n >= 300 && n < 400);
         if (n == 500) drain();
         r = $urandom_range(99);
         k = $urandom_range(15);
         if (r < 8) send_op(KIND_CREATE, k, 0, 0, 0);
         else if (r < 40)
            send_op(KIND_SIZE, k, ($urandom_range(9) == 0) ? $urandom_range(8192)
                    : $urandom_range(1200), 0, 0);
         else if (r < 95)
            send_op(KIND_WRITE, k, 0, ($urandom_range(7) == 0) ? $urandom_range(8191)
                    : $urandom_range(1300), $urandom_range(255));
         else send_op(KIND_NOP, k, $urandom_range(16383), $urandom_range(8191),
                      $urandom_range(255));
      end
      calm = 1'b0;
      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("fat_block_chain_manager: match");
      else $display("fat_block_chain_manager: mismatch");
      $finish;
   end

endmodule

[fat_block_chain_manager.f]
sv/fbcm_pkg.sv
sv/fbcm_ctrl.sv
sv/fbcm_dpath.sv
sv/fat_block_chain_manager.sv
tb/fat_block_chain_manager_chk.sv
tb/fat_block_chain_manager_tb.sv
